/* rtl/srw_pkg.sv */
// Package for the selective repeat window block: widths, codes, word formats.
// Used by every module of the block; depends on nothing.
`default_nettype none

package srw_pkg;

    localparam int C_MAX_WINDOW   = 64;
    localparam int C_SEQ_W        = 7;
    localparam int C_SLOT_W       = 6;
    localparam int C_CFG_W        = 3;
    localparam int C_IN_TDATA_W   = 8;
    localparam int C_OUT_TDATA_W  = 24;
    localparam int C_QUEUE_DEPTH  = 2;
    localparam logic [C_CFG_W-1:0] C_SEQ_BITS_RST = 3'd3;

    typedef enum logic [1:0] {
        OC_ACK_OK   = 2'd0,
        OC_ACK_LOST = 2'd1,
        OC_DAMAGED  = 2'd2,
        OC_LOST     = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        STS_RECEIVED    = 3'd0,
        STS_DUPLICATE   = 3'd1,
        STS_DAMAGED     = 3'd2,
        STS_LOST        = 3'd3,
        STS_NOT_PENDING = 3'd4,
        STS_TO_SEND     = 3'd5
    } t_status;

    // command class decided by the front end
    typedef enum logic [1:0] {
        CLS_OUTCOME = 2'd0,
        CLS_RANGE   = 2'd1,
        CLS_ROUND   = 2'd2
    } t_cls;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_CHECK  = 3'd1,
        S_SEARCH = 3'd2,
        S_EMIT   = 3'd3,
        S_SCAN   = 3'd4,
        S_SLIDE  = 3'd5,
        S_FLUSH  = 3'd6
    } t_state;

    typedef struct packed {
        t_cls                cls;
        logic [C_SLOT_W-1:0] slot;
        t_outcome            outcome;
    } t_cmd;

    typedef struct packed {
        logic [C_SEQ_W-1:0]  seq;
        logic [C_SLOT_W-1:0] slot;
        t_status             status;
        logic                ack;
        logic                last;
    } t_res;

    typedef struct packed {
        logic busy;
    } t_back_sts;

    // mask of the sequence space, width 0 treated as 1
    function automatic logic [C_SEQ_W-1:0] f_mask(input logic [C_CFG_W-1:0] b);
        logic [C_CFG_W-1:0] bb;
        logic [7:0]         full;
        bb   = (b == 3'd0) ? 3'd1 : b;
        full = (8'd1 << bb) - 8'd1;
        f_mask = full[C_SEQ_W-1:0];
    endfunction

    // window size: half the sequence space, capped at the slot count
    function automatic logic [C_SEQ_W-1:0] f_win(input logic [C_CFG_W-1:0] b,
                                                 input int unsigned maxw);
        logic [C_CFG_W-1:0] bb;
        logic [7:0]         half;
        bb   = (b == 3'd0) ? 3'd1 : b;
        half = (8'd1 << bb) >> 1;
        if (32'(half) > maxw) begin
            f_win = 7'(maxw);
        end else begin
            f_win = half[C_SEQ_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/selective_repeat_window.sv */
// Top level of the selective repeat window block: front end, queue, back end.
// Depends on srw_pkg, srw_front, srw_queue, srw_back.
//
//  channel   | direction | word                                   | handshake
//  ----------+-----------+----------------------------------------+----------------------
//  s_axis    | in        | tdata slot,outcome; tuser kind         | tvalid & tready
//  m_axis    | out       | tdata seq,slot,status,ack; tlast       | tvalid & tready
//  cfg       | in        | seq_bits                               | i_cfg_valid & o_cfg_ready
//
// An outcome word for a slot outside the window or already acked skips the search;
// a delivered frame searches the expected entries one per cycle, up to W (window size).
// An end-of-round word scans past the leading acked slots, then slides the window one
// slot per cycle through the single read port of the window memory, holding while the
// output stalls. Reset is synchronous; memories are not swept, per-entry valid bits give
// start values, so words are taken right after reset. A config write does the same.
// Input words queue (two deep) while the back end is busy or the output is stalled.
`default_nettype none

module selective_repeat_window
    import srw_pkg::*;
#(
    parameter int P_MAX_WINDOW = C_MAX_WINDOW
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [C_IN_TDATA_W-1:0]  s_axis_tdata,  // slot[5:0], outcome[7:6]
    input  wire logic                     s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [C_OUT_TDATA_W-1:0]      m_axis_tdata,  // seq[6:0], slot_out[12:7],
                                                         // status[15:13], ack_received[16]
    output logic                          m_axis_tlast,  // last
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [C_CFG_W-1:0]       i_cfg_data     // seq_bits
);

    logic               q_push, q_pop, q_empty, q_full;
    t_cmd               f_cmd, q_cmd;
    logic [C_SEQ_W-1:0] win;
    t_res               res;
    t_back_sts          back_sts;

    // config writes must be issued only while idle (the block does not enforce it); the port never pushes back
    assign o_cfg_ready = 1'b1;

    srw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_win         (win),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (f_cmd)
    );

    srw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    srw_back #(
        .P_MAX_WINDOW (P_MAX_WINDOW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_win      (win),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res),
        .o_sts      (back_sts)
    );

    // output word, first field in the low bits, zero padded to 24 bits
    assign m_axis_tdata = {7'd0, res.ack, res.status, res.slot, res.seq};
    assign m_axis_tlast = res.last;

    // back end only takes a command that is really there
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command taken from empty queue");

    // every command taken leaves the back end busy in the cycle after
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> back_sts.busy)
        else $error("back end idle right after taking a command");

    // no word is offered straight out of reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

/* rtl/srw_front.sv */
// Front end: takes input words and sorts them into commands for the queue.
// Depends on srw_pkg.
`default_nettype none

module srw_front
    import srw_pkg::*;
(
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [C_IN_TDATA_W-1:0] s_axis_tdata,  // slot[5:0], outcome[7:6]
    input  wire logic                    s_axis_tuser,  // kind
    input  wire logic [C_SEQ_W-1:0]      i_win,
    input  wire logic                    i_q_full,
    output logic                         o_push,
    output t_cmd                         o_cmd
);

    logic [C_SLOT_W-1:0] slot;

    assign slot          = s_axis_tdata[C_SLOT_W-1:0];
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cmd.slot    = slot;
        o_cmd.outcome = t_outcome'(s_axis_tdata[C_IN_TDATA_W-1:C_SLOT_W]);
        if (s_axis_tuser) begin
            o_cmd.cls = CLS_ROUND;
        end else if ({1'b0, slot} >= i_win) begin
            o_cmd.cls = CLS_RANGE;   // slot outside the window
        end else begin
            o_cmd.cls = CLS_OUTCOME;
        end
    end

endmodule

`default_nettype wire

/* rtl/srw_queue.sv */
// Short command queue between front and back end.
// Depends on srw_pkg.
`default_nettype none

module srw_queue
    import srw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty,
    output logic      o_full
);

    localparam int AW = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(C_QUEUE_DEPTH + 1);

    t_cmd            r_mem [C_QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [NW-1:0]   r_cnt;

    assign o_empty = (r_cnt == NW'(0));
    assign o_full  = (r_cnt == NW'(C_QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == C_QUEUE_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == C_QUEUE_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/srw_back.sv */
// Back end: window memories, receiver search, slide and pending list, output register.
// Depends on srw_pkg.
`default_nettype none

module srw_back
    import srw_pkg::*;
#(
    parameter int P_MAX_WINDOW = C_MAX_WINDOW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [C_CFG_W-1:0] i_cfg_data,
    output logic [C_SEQ_W-1:0]      o_win,
    input  wire logic               i_q_empty,
    input  wire t_cmd               i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_res                    o_res,
    output t_back_sts               o_sts
);

    localparam int IW = (P_MAX_WINDOW > 1) ? $clog2(P_MAX_WINDOW) : 1;
    localparam int CW = $clog2(P_MAX_WINDOW + 1);
    localparam logic [C_SEQ_W-1:0] L_NEXT_RST =
        f_win(C_SEQ_BITS_RST, P_MAX_WINDOW) & f_mask(C_SEQ_BITS_RST);

    // window sequence numbers and receiver expected set
    logic [C_SEQ_W-1:0] ws_mem [P_MAX_WINDOW];
    logic [C_SEQ_W-1:0] re_mem [P_MAX_WINDOW];

    t_state                  r_state, n_state;
    logic [C_CFG_W-1:0]      r_seq_bits, n_seq_bits;
    logic [C_SEQ_W-1:0]      r_nss, n_nss, r_nes, n_nes;
    logic [P_MAX_WINDOW-1:0] r_acked, n_acked, r_ws_v, n_ws_v, r_re_v, n_re_v;
    logic [C_SLOT_W-1:0]     r_slot, n_slot;
    t_outcome                r_outc, n_outc;
    logic [C_SEQ_W-1:0]      r_s, n_s;
    t_res                    r_res, n_res, r_out, n_out;
    logic                    r_ov, n_ov;
    logic [CW-1:0]           r_k, n_k, r_i, n_i;
    logic                    r_pv, n_pv, r_pref, n_pref, r_hv, n_hv;
    logic [IW-1:0]           r_pi, n_pi, r_hslot, n_hslot;
    logic [C_SEQ_W-1:0]      r_hseq, n_hseq;

    // registered read ports, with sampled valid bit and address
    logic [C_SEQ_W-1:0] r_ws_q, r_re_q;
    logic               r_ws_qv, r_re_qv;
    logic [IW-1:0]      r_ws_qi, r_re_qi;

    logic               ws_we, ws_re, re_we, re_re;
    logic [IW-1:0]      ws_wa, ws_ra, re_wa, re_ra;
    logic [C_SEQ_W-1:0] ws_wd, re_wd;

    logic [C_SEQ_W-1:0] win, mask, ws_data, re_data;
    logic               out_free;

    function automatic t_res f_res(input logic [C_SEQ_W-1:0] seq,
                                   input logic [C_SLOT_W-1:0] slot,
                                   input t_status st, input logic ack,
                                   input logic last);
        t_res r;
        r.seq    = seq;
        r.slot   = slot;
        r.status = st;
        r.ack    = ack;
        r.last   = last;
        return r;
    endfunction

    assign win      = f_win(r_seq_bits, P_MAX_WINDOW);
    assign mask     = f_mask(r_seq_bits);
    assign o_win    = win;
    // unwritten entries read as their own index
    assign ws_data  = r_ws_qv ? r_ws_q : C_SEQ_W'(r_ws_qi);
    assign re_data  = r_re_qv ? r_re_q : C_SEQ_W'(r_re_qi);
    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_res    = r_out;
    assign o_sts.busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            ws_mem[ws_wa] <= ws_wd;
        end
        if (ws_re) begin
            r_ws_q  <= ws_mem[ws_ra];
            r_ws_qv <= r_ws_v[ws_ra];
            r_ws_qi <= ws_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re_we) begin
            re_mem[re_wa] <= re_wd;
        end
        if (re_re) begin
            r_re_q  <= re_mem[re_ra];
            r_re_qv <= r_re_v[re_ra];
            r_re_qi <= re_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seq_bits <= C_SEQ_BITS_RST;
            r_nss      <= L_NEXT_RST;
            r_nes      <= L_NEXT_RST;
            r_acked    <= '0;
            r_ws_v     <= '0;
            r_re_v     <= '0;
            r_ov       <= 1'b0;
            r_pv       <= 1'b0;
            r_hv       <= 1'b0;
            r_k        <= '0;
            r_i        <= '0;
        end else begin
            r_state    <= n_state;
            r_seq_bits <= n_seq_bits;
            r_nss      <= n_nss;
            r_nes      <= n_nes;
            r_acked    <= n_acked;
            r_ws_v     <= n_ws_v;
            r_re_v     <= n_re_v;
            r_ov       <= n_ov;
            r_pv       <= n_pv;
            r_hv       <= n_hv;
            r_k        <= n_k;
            r_i        <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_outc  <= n_outc;
        r_s     <= n_s;
        r_res   <= n_res;
        r_out   <= n_out;
        r_pi    <= n_pi;
        r_pref  <= n_pref;
        r_hseq  <= n_hseq;
        r_hslot <= n_hslot;
    end

    always_comb begin
        logic               emit_need, cons, adv, fin, fin_ack;
        t_status            fin_st;
        logic [C_SEQ_W-1:0] new_seq;
        logic [7:0]         src;

        n_state    = r_state;
        n_seq_bits = r_seq_bits;
        n_nss      = r_nss;
        n_nes      = r_nes;
        n_acked    = r_acked;
        n_ws_v     = r_ws_v;
        n_re_v     = r_re_v;
        n_slot     = r_slot;
        n_outc     = r_outc;
        n_s        = r_s;
        n_res      = r_res;
        n_out      = r_out;
        n_ov       = r_ov && !i_ready;
        n_k        = r_k;
        n_i        = r_i;
        n_pv       = r_pv;
        n_pi       = r_pi;
        n_pref     = r_pref;
        n_hv       = r_hv;
        n_hseq     = r_hseq;
        n_hslot    = r_hslot;
        o_q_pop    = 1'b0;
        ws_we = 1'b0; ws_wa = '0; ws_wd = '0; ws_re = 1'b0; ws_ra = '0;
        re_we = 1'b0; re_wa = '0; re_wd = '0; re_re = 1'b0; re_ra = '0;
        emit_need = 1'b0;
        cons      = 1'b0;
        adv       = 1'b0;
        fin       = 1'b0;
        fin_st    = STS_DUPLICATE;
        fin_ack   = (r_outc == OC_ACK_OK);
        new_seq   = '0;
        src       = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_slot  = i_q_cmd.slot;
                    n_outc  = i_q_cmd.outcome;
                    case (i_q_cmd.cls)
                        CLS_RANGE: begin
                            n_res   = f_res('0, i_q_cmd.slot, STS_NOT_PENDING, 1'b0, 1'b1);
                            n_state = S_EMIT;
                        end
                        CLS_OUTCOME: begin
                            ws_re   = 1'b1;
                            ws_ra   = i_q_cmd.slot[IW-1:0];
                            n_state = S_CHECK;
                        end
                        default: begin
                            n_k     = '0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_s = ws_data;
                if (r_acked[r_slot[IW-1:0]]) begin
                    n_res   = f_res(ws_data, r_slot, STS_NOT_PENDING, 1'b1, 1'b1);
                    n_state = S_EMIT;
                end else if (r_outc == OC_DAMAGED || r_outc == OC_LOST) begin
                    n_res   = f_res(ws_data, r_slot,
                                    (r_outc == OC_DAMAGED) ? STS_DAMAGED : STS_LOST,
                                    1'b0, 1'b1);
                    n_state = S_EMIT;
                end else begin
                    re_re   = 1'b1;
                    re_ra   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // one expected entry compared per cycle
                if (re_data == r_s) begin
                    re_we  = 1'b1;
                    re_wa  = r_re_qi;
                    re_wd  = r_nes;
                    n_re_v[r_re_qi] = 1'b1;
                    n_nes  = (r_nes + 1'b1) & mask;
                    fin    = 1'b1;
                    fin_st = STS_RECEIVED;
                end else if (C_SEQ_W'(r_re_qi) + 7'd1 < win) begin
                    re_re = 1'b1;
                    re_ra = r_re_qi + 1'b1;
                end else begin
                    fin    = 1'b1;
                    fin_st = STS_DUPLICATE;
                end
                if (fin) begin
                    if (fin_ack) begin
                        n_acked[r_slot[IW-1:0]] = 1'b1;
                    end
                    n_res   = f_res(r_s, r_slot, fin_st, fin_ack, 1'b1);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // count leading acked slots, shifting the ack flags down as we go
                if (C_SEQ_W'(r_k) < win && r_acked[0]) begin
                    n_acked = r_acked >> 1;
                    n_k     = r_k + 1'b1;
                end else begin
                    n_i     = '0;
                    n_pv    = 1'b0;
                    n_hv    = 1'b0;
                    n_state = S_SLIDE;
                end
            end
            S_SLIDE: begin
                // stage r_pi holds the new content of slot r_pi; pending
                // words are held back one so the last one can be marked
                emit_need = r_pv && !r_acked[r_pi];
                cons      = r_pv && (!emit_need || !r_hv || out_free);
                adv       = !r_pv || cons;
                if (cons) begin
                    new_seq = r_pref ? r_nss : ws_data;
                    if (r_pref) begin
                        n_nss = (r_nss + 1'b1) & mask;
                    end
                    ws_we = 1'b1;
                    ws_wa = r_pi;
                    ws_wd = new_seq;
                    n_ws_v[r_pi] = 1'b1;
                    if (emit_need) begin
                        if (r_hv) begin
                            n_ov  = 1'b1;
                            n_out = f_res(r_hseq, C_SLOT_W'(r_hslot), STS_TO_SEND, 1'b0,
                                          1'b0);
                        end
                        n_hv    = 1'b1;
                        n_hseq  = new_seq;
                        n_hslot = r_pi;
                    end
                end
                if (adv) begin
                    if (C_SEQ_W'(r_i) < win) begin
                        src  = 8'(r_i) + 8'(r_k);
                        n_pv = 1'b1;
                        n_pi = r_i[IW-1:0];
                        n_i  = r_i + 1'b1;
                        if (src < {1'b0, win}) begin
                            ws_re  = 1'b1;
                            ws_ra  = src[IW-1:0];
                            n_pref = 1'b0;
                        end else begin
                            n_pref = 1'b1;   // refill from next send number
                        end
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = f_res(r_hseq, C_SLOT_W'(r_hslot), STS_TO_SEND, 1'b0, 1'b1);
                    n_hv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write puts both windows back to their start values
        if (i_cfg_we) begin
            n_seq_bits = i_cfg_data;
            n_nss      = f_win(i_cfg_data, P_MAX_WINDOW) & f_mask(i_cfg_data);
            n_nes      = f_win(i_cfg_data, P_MAX_WINDOW) & f_mask(i_cfg_data);
            n_acked    = '0;
            n_ws_v     = '0;
            n_re_v     = '0;
        end
    end

endmodule

`default_nettype wire

/* dv/selective_repeat_window_tb.sv */
// Self-checking testbench for selective_repeat_window: an ARQ link predictor in a small
// scoreboard class, stream drivers with random idling, stalls and config phases.
// Depends on srw_pkg and the selective_repeat_window RTL.

import srw_pkg::*;

// Tracks both link ends and queues the result words each input word should produce.
class link_scoreboard;
    int unsigned         seq_bits;
    int                  errors;
    logic [C_SEQ_W-1:0]  win_seq [C_MAX_WINDOW];
    bit                  win_acked [C_MAX_WINDOW];
    logic [C_SEQ_W-1:0]  rx_expected [C_MAX_WINDOW];
    logic [C_SEQ_W-1:0]  next_send;
    logic [C_SEQ_W-1:0]  next_expected;
    t_res                due_reports [$];

    function new();
        errors = 0;
        load_bits(int'(C_SEQ_BITS_RST));
    endfunction

    function logic [C_SEQ_W-1:0] space_mask();
        int unsigned b;
        b = (seq_bits == 0) ? 1 : seq_bits;
        return C_SEQ_W'((8'd1 << b) - 8'd1);
    endfunction

    function int unsigned win_size();
        int unsigned w;
        w = (int'(space_mask()) + 1) >> 1;
        if (w > C_MAX_WINDOW) w = C_MAX_WINDOW;
        return w;
    endfunction

    // register write: same effect as reset on both windows
    function void load_bits(int unsigned bits);
        logic [C_SEQ_W-1:0] m;
        seq_bits = bits;
        m = space_mask();
        for (int i = 0; i < C_MAX_WINDOW; i++) begin
            win_seq[i]     = C_SEQ_W'(i) & m;
            rx_expected[i] = C_SEQ_W'(i) & m;
            win_acked[i]   = 1'b0;
        end
        next_send     = C_SEQ_W'(win_size()) & m;
        next_expected = next_send;
    endfunction

    function void queue_report(logic [C_SEQ_W-1:0] seq, logic [C_SLOT_W-1:0] slot,
                               t_status st, logic ack, logic last);
        t_res r;
        r.seq    = seq;
        r.slot   = slot;
        r.status = st;
        r.ack    = ack;
        r.last   = last;
        due_reports.push_back(r);
    endfunction

    function int outstanding();
        return due_reports.size();
    endfunction

    // accepted input word: advance the link state, queue its results
    function void note_word(bit kind, logic [C_SLOT_W-1:0] slot, t_outcome oc);
        logic [C_SEQ_W-1:0] m;
        logic [C_SEQ_W-1:0] s;
        int unsigned        w;
        int unsigned        j;
        int unsigned        n;
        int                 tail;
        t_status            st;
        m = space_mask();
        w = win_size();
        if (!kind) begin
            if (slot >= w) begin
                queue_report('0, slot, STS_NOT_PENDING, 1'b0, 1'b1);
            end else if (win_acked[slot]) begin
                queue_report(win_seq[slot], slot, STS_NOT_PENDING, 1'b1, 1'b1);
            end else if (oc == OC_ACK_OK || oc == OC_ACK_LOST) begin
                s  = win_seq[slot];
                st = STS_DUPLICATE;
                for (int k = 0; k < w; k++) begin
                    if (rx_expected[k] == s) begin
                        rx_expected[k] = next_expected;
                        next_expected  = (next_expected + 1'b1) & m;
                        st = STS_RECEIVED;
                        break;
                    end
                end
                if (oc == OC_ACK_OK) win_acked[slot] = 1'b1;
                queue_report(s, slot, st, win_acked[slot], 1'b1);
            end else if (oc == OC_DAMAGED) begin
                queue_report(win_seq[slot], slot, STS_DAMAGED, 1'b0, 1'b1);
            end else begin
                queue_report(win_seq[slot], slot, STS_LOST, 1'b0, 1'b1);
            end
        end else begin
            // slide past the leading acked slots, refill the tail
            j = 0;
            while (j < w && win_acked[j]) j++;
            n = 0;
            for (int i = j; i < w; i++) begin
                win_seq[n]   = win_seq[i];
                win_acked[n] = win_acked[i];
                n++;
            end
            for (int i = n; i < w; i++) begin
                win_seq[i]   = next_send;
                next_send    = (next_send + 1'b1) & m;
                win_acked[i] = 1'b0;
            end
            tail = -1;
            for (int i = 0; i < w; i++) if (!win_acked[i]) tail = i;
            for (int i = 0; i < w; i++) begin
                if (!win_acked[i])
                    queue_report(win_seq[i], C_SLOT_W'(i), STS_TO_SEND, 1'b0, i == tail);
            end
        end
    endfunction

    // output log is capped; the count is not
    task report(string what);
        errors++;
        if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task check_report(logic [C_SEQ_W-1:0] seq, logic [C_SLOT_W-1:0] slot,
                      logic [2:0] status, logic ack, logic last);
        t_res want;
        if (due_reports.size() == 0) begin
            report($sformatf("unexpected word seq=%0d slot=%0d status=%0d ack=%0b last=%0b",
                             seq, slot, status, ack, last));
            return;
        end
        want = due_reports.pop_front();
        if (seq !== want.seq || slot !== want.slot || status !== 3'(want.status) ||
            ack !== want.ack || last !== want.last) begin
            report($sformatf("got seq=%0d slot=%0d status=%0d ack=%0b last=%0b, want %0d %0d %0d %0b %0b",
                             seq, slot, status, ack, last,
                             want.seq, want.slot, want.status, want.ack, want.last));
        end
    endtask
endclass

module selective_repeat_window_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int SETTLE       = 4;                    // idle gap before a config write
    localparam int END_WAIT     = 2 * C_MAX_WINDOW + 8; // longest round, then some
    localparam int HOLD_CYCLES  = 600;                  // long receiver hold-off
    localparam int PHASE_WORDS  = 30;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [C_IN_TDATA_W-1:0]   s_axis_tdata  = '0;    // slot[5:0], outcome[7:6]
    logic                      s_axis_tuser  = 1'b0;  // kind
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [C_OUT_TDATA_W-1:0]  m_axis_tdata;          // seq[6:0], slot_out[12:7],
                                                      // status[15:13], ack_received[16]
    logic                      m_axis_tlast;          // last
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [C_CFG_W-1:0]        i_cfg_data    = '0;    // seq_bits

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          rx_hold_req  = 1'b0;
    int unsigned words_sent   = 0;

    link_scoreboard sb = new();

    selective_repeat_window dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: random back-pressure, or a long hold-off counted here when requested.
    always @(posedge i_clk) begin : rx_side
        int unsigned hold_left;
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result monitor: every word taken on the master side is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tdata[6:0], m_axis_tdata[12:7], m_axis_tdata[15:13],
                            m_axis_tdata[16], m_axis_tlast);
    end

    // Offer one input word, with an optional random gap ahead of it. Returns at the edge
    // where it was taken; tvalid stays high so back-to-back words need no re-raise.
    task automatic push_word(bit kind, logic [C_SLOT_W-1:0] slot, t_outcome oc);
        int unsigned gap;
        gap = 0;
        while (gap < 30 && tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {oc, slot};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(kind, slot, oc);
        words_sent++;
    endtask

    // Stop offering and wait for every queued result to come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_seq_bits(int unsigned bits);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= C_CFG_W'(bits);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.load_bits(bits);
    endtask

    function automatic t_outcome pick_outcome();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return OC_ACK_OK;
        if (r < 65) return OC_ACK_LOST;
        if (r < 82) return OC_DAMAGED;
        return OC_LOST;
    endfunction

    // One link round: outcomes mostly walk the window from slot 0 so the window slides,
    // some hit random window slots (retransmits, duplicates), a few are noise beyond it.
    task automatic run_round();
        int unsigned w;
        int unsigned k;
        int unsigned r;
        logic [C_SLOT_W-1:0] slot;
        w = sb.win_size();
        k = $urandom_range(1, (w < 8) ? w : 8);
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(99);
            if (r < 60)      slot = C_SLOT_W'(i);
            else if (r < 90) slot = C_SLOT_W'($urandom_range(0, w - 1));
            else             slot = C_SLOT_W'($urandom_range(0, 63));
            push_word(1'b0, slot, pick_outcome());
        end
        // end of round; its slot and outcome fields are don't-care, so randomize them
        push_word(1'b1, C_SLOT_W'($urandom_range(0, 63)), t_outcome'($urandom_range(0, 3)));
    endtask

    initial begin : stimulus
        int unsigned settings [8] = '{0, 1, 7, 2, 5, 6, 4, 3};
        int unsigned start;
        bit          paused;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset width (3 bits, window of 4).
        push_word(1'b0, 6'd0,  OC_ACK_OK);    // received and acked
        push_word(1'b0, 6'd0,  OC_ACK_OK);    // already acked
        push_word(1'b0, 6'd1,  OC_ACK_LOST);  // received, ack lost
        push_word(1'b0, 6'd1,  OC_ACK_OK);    // retransmit: duplicate, now acked
        push_word(1'b0, 6'd2,  OC_DAMAGED);
        push_word(1'b0, 6'd3,  OC_LOST);
        push_word(1'b0, 6'd4,  OC_ACK_OK);    // first slot past the window
        push_word(1'b0, 6'd63, OC_LOST);      // top slot, past the window
        push_word(1'b0, 6'd42, OC_ACK_LOST);
        push_word(1'b0, 6'd21, OC_DAMAGED);
        push_word(1'b1, 6'd63, OC_LOST);      // end of round, fields all ones
        for (int i = 0; i < 4; i++) push_word(1'b0, 6'(i), OC_ACK_OK);
        push_word(1'b1, 6'd0,  OC_ACK_OK);    // whole window acked: full slide
        push_word(1'b1, 6'd0,  OC_ACK_OK);    // nothing acked: no slide
        push_word(1'b0, 6'd3,  OC_ACK_LOST);
        push_word(1'b0, 6'd3,  OC_DAMAGED);
        push_word(1'b0, 6'd0,  OC_ACK_OK);
        push_word(1'b1, 6'd0,  OC_ACK_OK);    // partial slide

        // Random phases: every width once, idling pattern rotating per phase.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            write_seq_bits(settings[p]);
            if (p == 2) begin
                // widest window with the output held off: input must back up
                tx_idle_pct = 0;
                rx_hold_req = 1'b1;
            end
            start  = words_sent;
            paused = 1'b0;
            while (words_sent - start < PHASE_WORDS) begin
                run_round();
                if (p == 4 && !paused && words_sent - start >= PHASE_WORDS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("selective_repeat_window regression: pass");
        end else begin
            $display("selective_repeat_window regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("selective_repeat_window regression: fail");
        $finish;
    end

endmodule
